// File: design/kalman_filter_2state_step_defines.svh
// Assertion macros for the two-state Kalman filter step.
`ifndef KALMAN_FILTER_2STATE_STEP_DEFINES_SVH
`define KALMAN_FILTER_2STATE_STEP_DEFINES_SVH

// Plain invariant, checked at every rising clock edge outside reset.
`define KFS_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define KFS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/kfs_pkg.sv
package kfs_pkg;

   localparam int WordBits = 32;
   localparam int FracBits = 16;
   localparam int PcBits   = 7;

   localparam logic [WordBits-1:0] UnityReset   = 32'd65536;
   localparam logic [WordBits-2:0] InitVarReset = 31'd6553600;

   typedef struct packed {
      logic signed [WordBits-1:0] measurement;
      logic signed [WordBits-1:0] motion_pos;
      logic signed [WordBits-1:0] motion_vel;
      logic                       restart;
   } req_data_type;

   typedef struct packed {
      logic signed [WordBits-1:0] est_pos;
      logic signed [WordBits-1:0] est_vel;
      logic signed [WordBits-1:0] var_00;
      logic signed [WordBits-1:0] var_01;
      logic signed [WordBits-1:0] var_10;
      logic signed [WordBits-1:0] var_11;
      logic                       update_skipped;
      logic                       saturated;
   } rsp_data_type;

   typedef enum logic [2:0] {
      CSR_TRANS_00 = 3'd0,
      CSR_TRANS_01 = 3'd1,
      CSR_TRANS_10 = 3'd2,
      CSR_TRANS_11 = 3'd3,
      CSR_OBS_0    = 3'd4,
      CSR_OBS_1    = 3'd5,
      CSR_MEAS_VAR = 3'd6,
      CSR_INIT_VAR = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_FIN,
      ST_DIVW,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_MUL,
      OP_ADD,
      OP_SUB,
      OP_DIV,
      OP_BLE,
      OP_END
   } op_type;

   // Operand codes: below 16 are scratch entries, 16 and above are named sources.
   typedef enum logic [5:0] {
      OPD_T0   = 6'd0,
      OPD_T1   = 6'd1,
      OPD_TY   = 6'd2,
      OPD_TB0  = 6'd3,
      OPD_TB1  = 6'd4,
      OPD_TA0  = 6'd5,
      OPD_TA1  = 6'd6,
      OPD_TS   = 6'd7,
      OPD_TK0  = 6'd8,
      OPD_TK1  = 6'd9,
      OPD_TX0  = 6'd10,
      OPD_TM00 = 6'd11,
      OPD_TM01 = 6'd12,
      OPD_TM10 = 6'd13,
      OPD_TM11 = 6'd14,
      OPD_POS  = 6'd16,
      OPD_VEL  = 6'd17,
      OPD_PA   = 6'd18,
      OPD_PB   = 6'd19,
      OPD_PC   = 6'd20,
      OPD_PD   = 6'd21,
      OPD_F00  = 6'd22,
      OPD_F01  = 6'd23,
      OPD_F10  = 6'd24,
      OPD_F11  = 6'd25,
      OPD_H0   = 6'd26,
      OPD_H1   = 6'd27,
      OPD_RV   = 6'd28,
      OPD_Z    = 6'd29,
      OPD_U0   = 6'd30,
      OPD_U1   = 6'd31,
      OPD_ZERO = 6'd32
   } opnd_type;

   typedef struct packed {
      op_type   op;
      opnd_type dst;
      opnd_type src_a;
      opnd_type src_b;
   } uop_type;

   localparam logic [PcBits-1:0] PcPred = 7'd35;
   localparam logic [PcBits-1:0] PcEnd  = 7'd68;

   function automatic uop_type uop(input op_type op, input opnd_type dst,
                                   input opnd_type a, input opnd_type b);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   // Microprogram: update then prediction.
   function automatic uop_type ucode(input logic [PcBits-1:0] pc);
      uop_type u;
      case (pc)
         7'd0:  u = uop(OP_MUL, OPD_T0,   OPD_H0,   OPD_POS);
         7'd1:  u = uop(OP_MUL, OPD_T1,   OPD_H1,   OPD_VEL);
         7'd2:  u = uop(OP_ADD, OPD_T0,   OPD_T0,   OPD_T1);
         7'd3:  u = uop(OP_SUB, OPD_TY,   OPD_Z,    OPD_T0);
         7'd4:  u = uop(OP_MUL, OPD_T0,   OPD_H0,   OPD_PA);
         7'd5:  u = uop(OP_MUL, OPD_T1,   OPD_H1,   OPD_PC);
         7'd6:  u = uop(OP_ADD, OPD_TB0,  OPD_T0,   OPD_T1);
         7'd7:  u = uop(OP_MUL, OPD_T0,   OPD_H0,   OPD_PB);
         7'd8:  u = uop(OP_MUL, OPD_T1,   OPD_H1,   OPD_PD);
         7'd9:  u = uop(OP_ADD, OPD_TB1,  OPD_T0,   OPD_T1);
         7'd10: u = uop(OP_MUL, OPD_T0,   OPD_PA,   OPD_H0);
         7'd11: u = uop(OP_MUL, OPD_T1,   OPD_PB,   OPD_H1);
         7'd12: u = uop(OP_ADD, OPD_TA0,  OPD_T0,   OPD_T1);
         7'd13: u = uop(OP_MUL, OPD_T0,   OPD_PC,   OPD_H0);
         7'd14: u = uop(OP_MUL, OPD_T1,   OPD_PD,   OPD_H1);
         7'd15: u = uop(OP_ADD, OPD_TA1,  OPD_T0,   OPD_T1);
         7'd16: u = uop(OP_MUL, OPD_T0,   OPD_TB0,  OPD_H0);
         7'd17: u = uop(OP_MUL, OPD_T1,   OPD_TB1,  OPD_H1);
         7'd18: u = uop(OP_ADD, OPD_T0,   OPD_T0,   OPD_T1);
         7'd19: u = uop(OP_ADD, OPD_TS,   OPD_T0,   OPD_RV);
         7'd20: u = uop(OP_BLE, OPD_ZERO, OPD_TS,   OPD_ZERO);
         7'd21: u = uop(OP_DIV, OPD_TK0,  OPD_TA0,  OPD_TS);
         7'd22: u = uop(OP_DIV, OPD_TK1,  OPD_TA1,  OPD_TS);
         7'd23: u = uop(OP_MUL, OPD_T0,   OPD_TK0,  OPD_TY);
         7'd24: u = uop(OP_ADD, OPD_POS,  OPD_POS,  OPD_T0);
         7'd25: u = uop(OP_MUL, OPD_T0,   OPD_TK1,  OPD_TY);
         7'd26: u = uop(OP_ADD, OPD_VEL,  OPD_VEL,  OPD_T0);
         7'd27: u = uop(OP_MUL, OPD_T0,   OPD_TK0,  OPD_TB0);
         7'd28: u = uop(OP_SUB, OPD_PA,   OPD_PA,   OPD_T0);
         7'd29: u = uop(OP_MUL, OPD_T0,   OPD_TK0,  OPD_TB1);
         7'd30: u = uop(OP_SUB, OPD_PB,   OPD_PB,   OPD_T0);
         7'd31: u = uop(OP_MUL, OPD_T0,   OPD_TK1,  OPD_TB0);
         7'd32: u = uop(OP_SUB, OPD_PC,   OPD_PC,   OPD_T0);
         7'd33: u = uop(OP_MUL, OPD_T0,   OPD_TK1,  OPD_TB1);
         7'd34: u = uop(OP_SUB, OPD_PD,   OPD_PD,   OPD_T0);
         7'd35: u = uop(OP_MUL, OPD_T0,   OPD_F00,  OPD_POS);
         7'd36: u = uop(OP_MUL, OPD_T1,   OPD_F01,  OPD_VEL);
         7'd37: u = uop(OP_ADD, OPD_T0,   OPD_T0,   OPD_T1);
         7'd38: u = uop(OP_ADD, OPD_TX0,  OPD_T0,   OPD_U0);
         7'd39: u = uop(OP_MUL, OPD_T0,   OPD_F10,  OPD_POS);
         7'd40: u = uop(OP_MUL, OPD_T1,   OPD_F11,  OPD_VEL);
         7'd41: u = uop(OP_ADD, OPD_T0,   OPD_T0,   OPD_T1);
         7'd42: u = uop(OP_ADD, OPD_VEL,  OPD_T0,   OPD_U1);
         7'd43: u = uop(OP_ADD, OPD_POS,  OPD_TX0,  OPD_ZERO);
         7'd44: u = uop(OP_MUL, OPD_T0,   OPD_F00,  OPD_PA);
         7'd45: u = uop(OP_MUL, OPD_T1,   OPD_F01,  OPD_PC);
         7'd46: u = uop(OP_ADD, OPD_TM00, OPD_T0,   OPD_T1);
         7'd47: u = uop(OP_MUL, OPD_T0,   OPD_F00,  OPD_PB);
         7'd48: u = uop(OP_MUL, OPD_T1,   OPD_F01,  OPD_PD);
         7'd49: u = uop(OP_ADD, OPD_TM01, OPD_T0,   OPD_T1);
         7'd50: u = uop(OP_MUL, OPD_T0,   OPD_F10,  OPD_PA);
         7'd51: u = uop(OP_MUL, OPD_T1,   OPD_F11,  OPD_PC);
         7'd52: u = uop(OP_ADD, OPD_TM10, OPD_T0,   OPD_T1);
         7'd53: u = uop(OP_MUL, OPD_T0,   OPD_F10,  OPD_PB);
         7'd54: u = uop(OP_MUL, OPD_T1,   OPD_F11,  OPD_PD);
         7'd55: u = uop(OP_ADD, OPD_TM11, OPD_T0,   OPD_T1);
         7'd56: u = uop(OP_MUL, OPD_T0,   OPD_TM00, OPD_F00);
         7'd57: u = uop(OP_MUL, OPD_T1,   OPD_TM01, OPD_F01);
         7'd58: u = uop(OP_ADD, OPD_PA,   OPD_T0,   OPD_T1);
         7'd59: u = uop(OP_MUL, OPD_T0,   OPD_TM00, OPD_F10);
         7'd60: u = uop(OP_MUL, OPD_T1,   OPD_TM01, OPD_F11);
         7'd61: u = uop(OP_ADD, OPD_PB,   OPD_T0,   OPD_T1);
         7'd62: u = uop(OP_MUL, OPD_T0,   OPD_TM10, OPD_F00);
         7'd63: u = uop(OP_MUL, OPD_T1,   OPD_TM11, OPD_F01);
         7'd64: u = uop(OP_ADD, OPD_PC,   OPD_T0,   OPD_T1);
         7'd65: u = uop(OP_MUL, OPD_T0,   OPD_TM10, OPD_F10);
         7'd66: u = uop(OP_MUL, OPD_T1,   OPD_TM11, OPD_F11);
         7'd67: u = uop(OP_ADD, OPD_PD,   OPD_T0,   OPD_T1);
         default: u = uop(OP_END, OPD_ZERO, OPD_ZERO, OPD_ZERO);
      endcase
      return u;
   endfunction

endpackage

// File: design/kalman_filter_2state_step.sv
// Two-state Kalman filter step on a microcoded shared datapath.
// The update is skipped when the innovation variance is not positive. Each
// micro-op reads its operands, executes and writes back; the branch has no
// write back, and each of the two gain divides waits for the divider.
// req_ready is high only when idle, so one transaction is in the datapath at a time.
// Reset: synchronous, active high; registers to defaults, state to zero, P=100*I.
module kalman_filter_2state_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kfs_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kfs_pkg::rsp_data_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import kfs_pkg::*;

`include "kalman_filter_2state_step_defines.svh"

   localparam int TmpDepth = 16;
   localparam int TmpBits  = $clog2(TmpDepth);

   // Configuration registers.
   logic signed [WordBits-1:0] f00_ff, f01_ff, f10_ff, f11_ff, h0_ff, h1_ff;
   logic        [WordBits-2:0] rv_ff, iv_ff;

   // Latched transaction inputs.
   logic signed [WordBits-1:0] z_ff, u0_ff, u1_ff;

   // Filter state.
   logic signed [WordBits-1:0] pos_ff, vel_ff, pa_ff, pb_ff, pcv_ff, pd_ff;

   // Sequencer.
   state_type          state_ff, state_in;
   logic [PcBits-1:0]  pc_ff, pc_in;
   uop_type            cur;
   logic               skip_ff, skip_in;
   logic               sat_ff;

   // Scratch memory, two registered reads.
   logic signed [WordBits-1:0] tmp_mem [TmpDepth];
   logic signed [WordBits-1:0] rd_a_ff, rd_b_ff;

   logic signed [WordBits-1:0] opa, opb;
   logic signed [WordBits-1:0] res_ff;
   logic                       res_sat_ff;
   logic signed [WordBits:0]   sum;
   logic signed [WordBits-1:0] alu_val;
   logic                       alu_sat;

   logic signed [WordBits-1:0] mul_res, div_res;
   logic                       mul_sat, div_sat, div_done;
   logic                       mul_load, div_start;

   logic                       wr_en;
   logic signed [WordBits-1:0] wr_val;
   logic                       wr_sat;

   rsp_data_type rsp_data_ff;
   logic         rsp_valid_ff;
   logic         req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur = ucode(pc_ff);

   // Configuration writes; only while idle by contract.
   always_ff @(posedge clock) begin
      if (reset) begin
         f00_ff <= UnityReset;
         f01_ff <= UnityReset;
         f10_ff <= '0;
         f11_ff <= UnityReset;
         h0_ff  <= UnityReset;
         h1_ff  <= '0;
         rv_ff  <= UnityReset[WordBits-2:0];
         iv_ff  <= InitVarReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRANS_00: f00_ff <= csr_data;
            CSR_TRANS_01: f01_ff <= csr_data;
            CSR_TRANS_10: f10_ff <= csr_data;
            CSR_TRANS_11: f11_ff <= csr_data;
            CSR_OBS_0:    h0_ff  <= csr_data;
            CSR_OBS_1:    h1_ff  <= csr_data;
            CSR_MEAS_VAR: rv_ff  <= csr_data[WordBits-2:0];
            CSR_INIT_VAR: iv_ff  <= csr_data[WordBits-2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         z_ff  <= req_data.measurement;
         u0_ff <= req_data.motion_pos;
         u1_ff <= req_data.motion_vel;
      end
   end

   // Named operand sources (scratch entries come from the memory).
   function automatic logic signed [WordBits-1:0] named_src(input opnd_type code,
         input logic signed [WordBits-1:0] pos, vel, pa, pb, pc, pd,
         input logic signed [WordBits-1:0] f00, f01, f10, f11, h0, h1,
         input logic [WordBits-2:0] rv,
         input logic signed [WordBits-1:0] z, u0, u1);
      logic signed [WordBits-1:0] v;
      case (code)
         OPD_POS: v = pos;
         OPD_VEL: v = vel;
         OPD_PA:  v = pa;
         OPD_PB:  v = pb;
         OPD_PC:  v = pc;
         OPD_PD:  v = pd;
         OPD_F00: v = f00;
         OPD_F01: v = f01;
         OPD_F10: v = f10;
         OPD_F11: v = f11;
         OPD_H0:  v = h0;
         OPD_H1:  v = h1;
         OPD_RV:  v = {1'b0, rv};
         OPD_Z:   v = z;
         OPD_U0:  v = u0;
         OPD_U1:  v = u1;
         default: v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      if (cur.src_a[5:4] == 2'b00) begin
         opa = rd_a_ff;
      end else begin
         opa = named_src(cur.src_a, pos_ff, vel_ff, pa_ff, pb_ff, pcv_ff, pd_ff,
                         f00_ff, f01_ff, f10_ff, f11_ff, h0_ff, h1_ff, rv_ff,
                         z_ff, u0_ff, u1_ff);
      end
      if (cur.src_b[5:4] == 2'b00) begin
         opb = rd_b_ff;
      end else begin
         opb = named_src(cur.src_b, pos_ff, vel_ff, pa_ff, pb_ff, pcv_ff, pd_ff,
                         f00_ff, f01_ff, f10_ff, f11_ff, h0_ff, h1_ff, rv_ff,
                         z_ff, u0_ff, u1_ff);
      end
   end

   // Saturating add/sub.
   always_comb begin
      if (cur.op == OP_SUB) begin
         sum = {opa[WordBits-1], opa} - {opb[WordBits-1], opb};
      end else begin
         sum = {opa[WordBits-1], opa} + {opb[WordBits-1], opb};
      end
      alu_sat = (sum[WordBits] != sum[WordBits-1]);
      if (alu_sat) begin
         alu_val = sum[WordBits] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      end else begin
         alu_val = sum[WordBits-1:0];
      end
   end

   kfs_mul u_mul (
      .clock  (clock),
      .load   (mul_load),
      .opa    (opa),
      .opb    (opb),
      .result (mul_res),
      .sat    (mul_sat)
   );

   kfs_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (opa),
      .den    (opb),
      .done   (div_done),
      .result (div_res),
      .sat    (div_sat)
   );

   // Sequencer: next state, pc and write-back strobes.
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      skip_in   = skip_ff;
      mul_load  = 1'b0;
      div_start = 1'b0;
      wr_en     = 1'b0;
      wr_val    = res_ff;
      wr_sat    = res_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_READ;
               pc_in    = '0;
               skip_in  = 1'b0;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            case (cur.op)
               OP_MUL: begin
                  mul_load = 1'b1;
                  state_in = ST_FIN;
               end
               OP_ADD, OP_SUB: state_in = ST_FIN;
               OP_DIV: begin
                  div_start = 1'b1;
                  state_in  = ST_DIVW;
               end
               OP_BLE: begin
                  state_in = ST_READ;
                  if (opa <= 0) begin
                     skip_in = 1'b1;
                     pc_in   = PcPred;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_FIN: begin
            wr_en = 1'b1;
            if (cur.op == OP_MUL) begin
               wr_val = mul_res;
               wr_sat = mul_sat;
            end
            pc_in    = pc_ff + 1'b1;
            state_in = ST_READ;
         end
         ST_DIVW: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_val   = div_res;
               wr_sat   = div_sat;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         skip_ff  <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         res_ff     <= alu_val;
         res_sat_ff <= alu_sat;
      end
   end

   // Scratch memory.
   always_ff @(posedge clock) begin
      if (wr_en && (cur.dst[5:4] == 2'b00)) begin
         tmp_mem[cur.dst[TmpBits-1:0]] <= wr_val;
      end
      if (state_ff == ST_READ) begin
         rd_a_ff <= tmp_mem[cur.src_a[TmpBits-1:0]];
         rd_b_ff <= tmp_mem[cur.src_b[TmpBits-1:0]];
      end
   end

   // Filter state: restart on an accepted item with restart set, otherwise micro-op write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
         pa_ff  <= {1'b0, InitVarReset};
         pb_ff  <= '0;
         pcv_ff <= '0;
         pd_ff  <= {1'b0, InitVarReset};
      end else if (req_acc && req_data.restart) begin
         pos_ff <= '0;
         vel_ff <= '0;
         pa_ff  <= {1'b0, iv_ff};
         pb_ff  <= '0;
         pcv_ff <= '0;
         pd_ff  <= {1'b0, iv_ff};
      end else if (wr_en) begin
         case (cur.dst)
            OPD_POS: pos_ff <= wr_val;
            OPD_VEL: vel_ff <= wr_val;
            OPD_PA:  pa_ff  <= wr_val;
            OPD_PB:  pb_ff  <= wr_val;
            OPD_PC:  pcv_ff <= wr_val;
            OPD_PD:  pd_ff  <= wr_val;
            default: ;
         endcase
      end
   end

   // Sticky clip flag per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else if (req_acc) begin
         sat_ff <= 1'b0;
      end else if (wr_en && wr_sat) begin
         sat_ff <= 1'b1;
      end
   end

   // Result register: frees the datapath while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.est_pos        <= pos_ff;
         rsp_data_ff.est_vel        <= vel_ff;
         rsp_data_ff.var_00         <= pa_ff;
         rsp_data_ff.var_01         <= pb_ff;
         rsp_data_ff.var_10         <= pcv_ff;
         rsp_data_ff.var_11         <= pd_ff;
         rsp_data_ff.update_skipped <= skip_ff;
         rsp_data_ff.saturated      <= sat_ff;
      end
   end

   `KFS_ASSERT_NEXT(a_accept_starts, req_acc, state_ff == ST_READ, "accept did not start sequence")
   `KFS_ASSERT(a_div_done_wait, !div_done || (state_ff == ST_DIVW), "divide finished outside wait")
   `KFS_ASSERT(a_pc_range, pc_ff <= PcEnd, "microprogram counter out of range")

endmodule

// File: design/kfs_mul.sv
// Fixed-point multiply: magnitude product registered, then round half away
// from zero, drop fraction bits and clip to the word range.
module kfs_mul (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic signed [kfs_pkg::WordBits-1:0]  opa,
   input  logic signed [kfs_pkg::WordBits-1:0]  opb,
   output logic signed [kfs_pkg::WordBits-1:0]  result,
   output logic                                 sat
);
   import kfs_pkg::*;

   localparam int ProdBits = 2 * WordBits;
   localparam int QBits    = ProdBits + 1 - FracBits;

   logic [ProdBits-1:0] prod_ff;
   logic                neg_ff;
   logic [WordBits-1:0] mag_a;
   logic [WordBits-1:0] mag_b;
   logic [ProdBits:0]   rnd;
   logic [QBits-1:0]    quo;
   logic [QBits-1:0]    lim;

   assign mag_a = opa[WordBits-1] ? (~opa + 1'b1) : opa;
   assign mag_b = opb[WordBits-1] ? (~opb + 1'b1) : opb;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= mag_a * mag_b;
         neg_ff  <= opa[WordBits-1] ^ opb[WordBits-1];
      end
   end

   assign rnd = {1'b0, prod_ff} + ((ProdBits+1)'(1) << (FracBits - 1));
   assign quo = rnd[ProdBits:FracBits];
   assign lim = neg_ff ? (QBits'(1) << (WordBits - 1)) : ((QBits'(1) << (WordBits - 1)) - 1'b1);

   always_comb begin
      sat = (quo > lim);
      if (sat) begin
         result = neg_ff ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      end else if (neg_ff) begin
         result = ~quo[WordBits-1:0] + 1'b1;
      end else begin
         result = quo[WordBits-1:0];
      end
   end

endmodule

// File: design/kfs_div.sv
// Fixed-point divide, one quotient bit per cycle, restoring.
// Divisor is positive; quotient truncates toward zero and clips.
module kfs_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [kfs_pkg::WordBits-1:0]  num,
   input  logic signed [kfs_pkg::WordBits-1:0]  den,
   output logic                                 done,
   output logic signed [kfs_pkg::WordBits-1:0]  result,
   output logic                                 sat
);
   import kfs_pkg::*;

   localparam int DvBits  = WordBits + FracBits;
   localparam int CntBits = $clog2(DvBits + 1);

   logic [DvBits-1:0]   qd_ff;
   logic [WordBits-1:0] rem_ff;
   logic [WordBits-1:0] den_ff;
   logic                neg_ff;
   logic [CntBits-1:0]  cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [WordBits:0]   rem_sh;
   logic                take;
   logic [WordBits-1:0] mag_n;
   logic [DvBits-1:0]   lim;

   assign mag_n  = num[WordBits-1] ? (~num + 1'b1) : num;
   assign rem_sh = {rem_ff, qd_ff[DvBits-1]};
   assign take   = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntBits'(DvBits);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         qd_ff  <= {mag_n, {FracBits{1'b0}}};
         rem_ff <= '0;
         den_ff <= den;
         neg_ff <= num[WordBits-1];
      end else if (busy_ff) begin
         qd_ff  <= {qd_ff[DvBits-2:0], take};
         rem_ff <= take ? WordBits'(rem_sh - {1'b0, den_ff}) : rem_sh[WordBits-1:0];
      end
   end

   assign done = done_ff;
   assign lim  = neg_ff ? (DvBits'(1) << (WordBits - 1)) : ((DvBits'(1) << (WordBits - 1)) - 1'b1);

   always_comb begin
      sat = (qd_ff > lim);
      if (sat) begin
         result = neg_ff ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      end else if (neg_ff) begin
         result = ~qd_ff[WordBits-1:0] + 1'b1;
      end else begin
         result = qd_ff[WordBits-1:0];
      end
   end

endmodule

// File: bench/tb_kalman_filter_2state_step.sv
module tb_kalman_filter_2state_step;
   import kfs_pkg::*;

   localparam int StallCycles = 1500;
   localparam int QuietLimit  = 20000;
   localparam int DrainCycles = 400;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;

   kalman_filter_2state_step uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 4 time unit clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ------------------------------------------------------------------
   // Filter predictor: its own copy of the registers and the filter state.
   // Every intermediate is kept in a 64-bit signed word and clipped to the
   // 32-bit range; clip_seen collects the saturation flag of one step.
   // ------------------------------------------------------------------
   logic [31:0] shadow_reg [8];
   longint      track_pos, track_vel, track_p00, track_p01, track_p10, track_p11;
   bit          clip_seen;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) begin
         clip_seen = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clip_seen = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // signed value from magnitude, clipped to the word range
   function automatic longint signed_of(bit neg, longint unsigned m);
      if (neg) begin
         if (m > 64'd2147483648) begin
            clip_seen = 1'b1;
            return -64'sd2147483648;
         end
         return -longint'(m);
      end
      if (m > 64'd2147483647) begin
         clip_seen = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(m);
   endfunction

   // Q16.16 product, rounded half away from zero
   function automatic longint qmul(longint a, longint b);
      longint unsigned prod;
      prod = magnitude(a) * magnitude(b);
      prod = (prod + 64'd32768) >> FracBits;
      return signed_of((a < 0) != (b < 0), prod);
   endfunction

   // Q16.16 quotient, truncated toward zero; den is positive
   function automatic longint qdiv(longint num, longint den);
      longint unsigned quo;
      quo = (magnitude(num) << FracBits) / longint'(den);
      return signed_of(num < 0, quo);
   endfunction

   function automatic longint qadd(longint a, longint b);
      return clip32(a + b);
   endfunction

   function automatic longint qsub(longint a, longint b);
      return clip32(a - b);
   endfunction

   function automatic longint sreg(int idx);
      return longint'($signed(shadow_reg[idx]));
   endfunction

   function automatic rsp_data_type filter_step(req_data_type item);
      rsp_data_type res;
      longint f00, f01, f10, f11, h0, h1, rv, z, u0, u1;
      longint x0, x1, p00, p01, p10, p11, b0, b1, a0, a1, s, y, k0, k1;
      longint m00, m01, m10, m11;
      bit     skip;
      clip_seen = 1'b0;
      skip = 1'b0;
      f00 = sreg(CSR_TRANS_00);
      f01 = sreg(CSR_TRANS_01);
      f10 = sreg(CSR_TRANS_10);
      f11 = sreg(CSR_TRANS_11);
      h0  = sreg(CSR_OBS_0);
      h1  = sreg(CSR_OBS_1);
      rv  = longint'(shadow_reg[CSR_MEAS_VAR] & 32'h7fffffff);
      z   = longint'(item.measurement);
      u0  = longint'(item.motion_pos);
      u1  = longint'(item.motion_vel);
      if (item.restart) begin
         track_pos = 0;
         track_vel = 0;
         track_p00 = longint'(shadow_reg[CSR_INIT_VAR] & 32'h7fffffff);
         track_p01 = 0;
         track_p10 = 0;
         track_p11 = track_p00;
      end
      x0 = track_pos;
      x1 = track_vel;
      p00 = track_p00;
      p01 = track_p01;
      p10 = track_p10;
      p11 = track_p11;

      // measurement update
      y  = qsub(z, qadd(qmul(h0, x0), qmul(h1, x1)));
      b0 = qadd(qmul(h0, p00), qmul(h1, p10));
      b1 = qadd(qmul(h0, p01), qmul(h1, p11));
      a0 = qadd(qmul(p00, h0), qmul(p01, h1));
      a1 = qadd(qmul(p10, h0), qmul(p11, h1));
      s  = qadd(qadd(qmul(b0, h0), qmul(b1, h1)), rv);
      if (s <= 0) begin
         skip = 1'b1;
      end else begin
         k0  = qdiv(a0, s);
         k1  = qdiv(a1, s);
         x0  = qadd(x0, qmul(k0, y));
         x1  = qadd(x1, qmul(k1, y));
         p00 = qsub(p00, qmul(k0, b0));
         p01 = qsub(p01, qmul(k0, b1));
         p10 = qsub(p10, qmul(k1, b0));
         p11 = qsub(p11, qmul(k1, b1));
      end

      // prediction, no process noise
      track_pos = qadd(qadd(qmul(f00, x0), qmul(f01, x1)), u0);
      track_vel = qadd(qadd(qmul(f10, x0), qmul(f11, x1)), u1);
      m00 = qadd(qmul(f00, p00), qmul(f01, p10));
      m01 = qadd(qmul(f00, p01), qmul(f01, p11));
      m10 = qadd(qmul(f10, p00), qmul(f11, p10));
      m11 = qadd(qmul(f10, p01), qmul(f11, p11));
      track_p00 = qadd(qmul(m00, f00), qmul(m01, f01));
      track_p01 = qadd(qmul(m00, f10), qmul(m01, f11));
      track_p10 = qadd(qmul(m10, f00), qmul(m11, f01));
      track_p11 = qadd(qmul(m10, f10), qmul(m11, f11));

      res.est_pos        = track_pos[31:0];
      res.est_vel        = track_vel[31:0];
      res.var_00         = track_p00[31:0];
      res.var_01         = track_p01[31:0];
      res.var_10         = track_p10[31:0];
      res.var_11         = track_p11[31:0];
      res.update_skipped = skip;
      res.saturated      = clip_seen;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Queues and bookkeeping
   // ------------------------------------------------------------------
   req_data_type pending_steps [$];   // items waiting for the driver
   rsp_data_type expected_est  [$];   // predicted results, oldest first
   int  error_count;
   bit  req_taken;        // set at the edge an item was accepted
   bit  calm;             // no idling in the last part of the run
   int  stall_asks;       // bumped by the stimulus to ask for a long hold
   int  stall_seen;
   int  hold_left;
   int  send_gap;
   int  recv_gap;
   int  quiet_cycles;

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // Monitor: predicts on each accepted item, checks each accepted result.
   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            shadow_reg[csr_index] = csr_data;
         end
         if (req_valid && req_ready) begin
            expected_est.push_back(filter_step(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_est.size() == 0) begin
               flag_mismatch("unexpected transaction", 32'h0, 32'h0);
            end else begin
               want = expected_est.pop_front();
               if (rsp_data.est_pos !== want.est_pos)
                  flag_mismatch("est_pos", rsp_data.est_pos, want.est_pos);
               if (rsp_data.est_vel !== want.est_vel)
                  flag_mismatch("est_vel", rsp_data.est_vel, want.est_vel);
               if (rsp_data.var_00 !== want.var_00)
                  flag_mismatch("var_00", rsp_data.var_00, want.var_00);
               if (rsp_data.var_01 !== want.var_01)
                  flag_mismatch("var_01", rsp_data.var_01, want.var_01);
               if (rsp_data.var_10 !== want.var_10)
                  flag_mismatch("var_10", rsp_data.var_10, want.var_10);
               if (rsp_data.var_11 !== want.var_11)
                  flag_mismatch("var_11", rsp_data.var_11, want.var_11);
               if (rsp_data.update_skipped !== want.update_skipped)
                  flag_mismatch("update_skipped", rsp_data.update_skipped,
                                want.update_skipped);
               if (rsp_data.saturated !== want.saturated)
                  flag_mismatch("saturated", rsp_data.saturated, want.saturated);
            end
         end
      end
   end

   // Driver: valid stays up with a steady payload until the transaction
   // is taken; outside the calm part, idle gaps sometimes fall between items.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_steps.size() != 0) begin
            req_data  <= pending_steps.pop_front();
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               send_gap <= $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random short stalls plus the long hold on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_gap   <= 0;
         hold_left  <= 0;
         stall_seen <= 0;
      end else if (stall_asks != stall_seen) begin
         stall_seen <= stall_asks;
         hold_left  <= StallCycles;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 4) == 0)
            recv_gap <= $urandom_range(1, 3);
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: w = 32'h7fffffff;
               1: w = 32'h80000000;
               2: w = 32'h0;
               3: w = 32'h1;
               default: w = 32'hffffffff;
            endcase
         end
         1: w = $urandom;
         default: w = $urandom_range(0, 32'h02000000) - 32'h01000000;
      endcase
      return w;
   endfunction

   function automatic req_data_type make_step(bit wild);
      req_data_type it;
      if (wild) begin
         it.measurement = pick_word();
         it.motion_pos  = pick_word();
         it.motion_vel  = pick_word();
         it.restart     = $urandom_range(0, 7) == 0;
      end else begin
         // tracking-style sequence: modest measurements and motion
         it.measurement = $urandom_range(0, 32'h01000000) - 32'h00800000;
         it.motion_pos  = $urandom_range(0, 32'h00020000) - 32'h00010000;
         it.motion_vel  = $urandom_range(0, 32'h00020000) - 32'h00010000;
         it.restart     = $urandom_range(0, 39) == 0;
      end
      return it;
   endfunction

   function automatic req_data_type fixed_step(logic [31:0] z, logic [31:0] u0,
                                               logic [31:0] u1, logic rs);
      req_data_type it;
      it.measurement = z;
      it.motion_pos  = u0;
      it.motion_vel  = u1;
      it.restart     = rs;
      return it;
   endfunction

   task automatic csr_write(csr_idx_type idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for all results, then a margin for the block to settle.
   task automatic drain();
      while (pending_steps.size() != 0 || req_valid || expected_est.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // mode 0: tracking setup, 1: random words, 2: extremes
   task automatic load_config(int mode);
      csr_idx_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = csr_idx_type'(i);
         case (mode)
            0: begin
               case (idx)
                  CSR_TRANS_00, CSR_TRANS_11: csr_write(idx, UnityReset);
                  CSR_TRANS_01: csr_write(idx, $urandom_range(0, 32'h00010000));
                  CSR_TRANS_10: csr_write(idx, $urandom_range(0, 32'h00000800));
                  CSR_OBS_0:    csr_write(idx, $urandom_range(32'h8000, 32'h20000));
                  CSR_OBS_1:    csr_write(idx, $urandom_range(0, 32'h4000));
                  CSR_MEAS_VAR: csr_write(idx, $urandom_range(0, 32'h00100000));
                  default:      csr_write(idx, $urandom_range(0, 32'h01000000));
               endcase
            end
            1: csr_write(idx, $urandom);
            default: begin
               case ($urandom_range(0, 3))
                  0: csr_write(idx, 32'h7fffffff);
                  1: csr_write(idx, 32'h80000000);
                  2: csr_write(idx, 32'h0);
                  default: csr_write(idx, 32'hffffffff);
               endcase
            end
         endcase
      end
   endtask

   initial begin
      int mode;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_TRANS_00;
      csr_data      = '0;
      error_count   = 0;
      calm          = 1'b0;
      stall_asks    = 0;
      quiet_cycles  = 0;
      track_pos     = 0;
      track_vel     = 0;
      track_p00     = longint'(InitVarReset);
      track_p01     = 0;
      track_p10     = 0;
      track_p11     = longint'(InitVarReset);
      shadow_reg[CSR_TRANS_00] = UnityReset;
      shadow_reg[CSR_TRANS_01] = UnityReset;
      shadow_reg[CSR_TRANS_10] = '0;
      shadow_reg[CSR_TRANS_11] = UnityReset;
      shadow_reg[CSR_OBS_0]    = UnityReset;
      shadow_reg[CSR_OBS_1]    = '0;
      shadow_reg[CSR_MEAS_VAR] = UnityReset;
      shadow_reg[CSR_INIT_VAR] = {1'b0, InitVarReset};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset configuration: field extremes, restart both ways.
      pending_steps.push_back(fixed_step(32'h00010000, 32'h0, 32'h0, 1'b0));
      pending_steps.push_back(fixed_step(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
      pending_steps.push_back(fixed_step(32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
      pending_steps.push_back(fixed_step(32'h0, 32'h0, 32'h0, 1'b1));
      pending_steps.push_back(fixed_step(32'hffffffff, 32'h1, 32'hffffffff, 1'b0));
      pending_steps.push_back(fixed_step(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1));
      pending_steps.push_back(fixed_step(32'h00050000, 32'h00010000, 32'h0, 1'b0));
      pending_steps.push_back(fixed_step(32'hfffb0000, 32'h0, 32'hffff0000, 1'b0));
      drain();

      // Zero observation row and zero noise: innovation variance is zero, update skipped.
      csr_write(CSR_OBS_0, 32'h0);
      csr_write(CSR_OBS_1, 32'h0);
      csr_write(CSR_MEAS_VAR, 32'h0);
      pending_steps.push_back(fixed_step(32'h00030000, 32'h00010000, 32'h0, 1'b1));
      pending_steps.push_back(fixed_step(32'h7fffffff, 32'h0, 32'h00010000, 1'b0));
      // Negative position weight with huge covariance forces clipping.
      drain();
      csr_write(CSR_OBS_0, 32'h80000000);
      csr_write(CSR_INIT_VAR, 32'h7fffffff);
      csr_write(CSR_TRANS_01, 32'h7fffffff);
      pending_steps.push_back(fixed_step(32'h00010000, 32'h0, 32'h0, 1'b1));
      pending_steps.push_back(fixed_step(32'h80000000, 32'h7fffffff, 32'h0, 1'b0));
      pending_steps.push_back(fixed_step(32'h0, 32'h0, 32'h0, 1'b0));
      drain();

      // Random phases; settings vary between them.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            1: mode = 1;
            3: mode = 2;
            default: mode = 0;
         endcase
         load_config(mode);
         if (ph == 11)
            calm = 1'b1;
         pending_steps.push_back(fixed_step(32'h0, 32'h0, 32'h0, 1'b1));
         for (int n = 0; n < 139; n++)
            pending_steps.push_back(make_step($urandom_range(0, 5) == 0));
         // Long receiver hold while the sender keeps offering items.
         if (ph == 2)
            stall_asks = stall_asks + 1;
         drain();
      end

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/kfs_pkg.sv
design/kfs_mul.sv
design/kfs_div.sv
design/kalman_filter_2state_step.sv
bench/tb_kalman_filter_2state_step.sv
